### hdl/generational_handle_table_unit_macros.svh
// assertion macros for the handle table unit
// all checks are clocked on clk_i and quiet while rst_ni is low
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define GHT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("handle table check failed");

// next-cycle implication
`define GHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("handle table check failed");

`endif

### hdl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// shared types, sizes and codes of the generational handle table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
  localparam int SLOT_CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int GEN_W       = 32;
  localparam int RIGHTS_W    = 3;
  localparam int OUT_INDEX_W = 6;

  // request kinds
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CHECK   = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  // status and stored error codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd1;
  localparam logic [1:0] ST_PERM       = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [GEN_W-1:0]    handle_index;
    logic [GEN_W-1:0]    handle_generation;
    logic [RIGHTS_W-1:0] access_mask;
    logic [RIGHTS_W-1:0] new_rights;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [OUT_INDEX_W-1:0] out_index;
    logic [GEN_W-1:0]       out_generation;
    logic [1:0]             slot_error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic rd_slot;
    logic rd_stack;
    logic use_pop;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_alloc;
    logic stack_nonempty;
    logic out_valid;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// request sequencer: capture, slot read, optional pop read, execute
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               out_stall_i,
  input  wire ght_pkg::dp_status_t st_i,
  output ght_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_POP  = 4'b0100,
    S_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_free;
  logic   accept;

  assign out_free   = !st_i.out_valid || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_EXEC) && out_free));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_READ;
      end
      S_READ: begin
        if (st_i.req_alloc && st_i.stack_nonempty) state_d = S_POP;
        else state_d = S_EXEC;
      end
      S_POP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = accept ? S_READ : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_req = accept;
    cmd_o.rd_slot  = (state_q == S_READ) || (state_q == S_POP);
    cmd_o.rd_stack = (state_q == S_READ);
    cmd_o.use_pop  = (state_q == S_POP);
    cmd_o.exec     = (state_q == S_EXEC) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/ght_datapath.sv
// ----------------------------------------------------------------------------
// ght_datapath
// slot memories, free stack, counters and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ght_pkg::in_item_t  in_data_i,
  input  wire logic               out_stall_i,
  input  wire ght_pkg::ctrl_cmd_t cmd_i,
  output ght_pkg::dp_status_t     st_o,
  output logic                    out_valid_o,
  output ght_pkg::out_item_t      out_data_o
);

  localparam int IW = ght_pkg::SLOT_IDX_W;
  localparam int CW = ght_pkg::SLOT_CNT_W;
  localparam int GW = ght_pkg::GEN_W;
  localparam int RW = ght_pkg::RIGHTS_W;

  // slot memories and free stack
  logic [GW-1:0] gen_mem    [ght_pkg::SLOT_COUNT];
  logic [RW-1:0] rights_mem [ght_pkg::SLOT_COUNT];
  logic [1:0]    err_mem    [ght_pkg::SLOT_COUNT];
  logic [IW-1:0] stack_mem  [ght_pkg::SLOT_COUNT];

  ght_pkg::in_item_t  req_q;
  ght_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [CW-1:0] free_count_q, free_count_d;
  logic [CW-1:0] high_water_q, high_water_d;
  logic [CW-1:0] fc_dec;

  logic [GW-1:0] gen_rd_q;
  logic [RW-1:0] rights_rd_q;
  logic [1:0]    err_rd_q;
  logic [IW-1:0] stack_rd_q;

  logic [IW-1:0] rd_addr;
  logic [IW-1:0] req_idx;

  logic          gen_we, rights_we, err_we, stack_we;
  logic [IW-1:0] gen_wa, slot_wa, stack_wa;
  logic [GW-1:0] gen_wd;
  logic [1:0]    err_wd;
  logic [IW-1:0] stack_wd;

  logic idx_in_range, handle_ok, hw_avail, stack_room;

  assign req_idx = req_q.handle_index[IW-1:0];
  assign fc_dec  = free_count_q - CW'(1);
  assign rd_addr = cmd_i.use_pop ? stack_rd_q : req_idx;

  assign idx_in_range = (req_q.handle_index[GW-1:IW] == '0) && (CW'(req_idx) < high_water_q);
  assign handle_ok    = idx_in_range && (gen_rd_q == req_q.handle_generation);
  assign hw_avail     = high_water_q < CW'(ght_pkg::SLOT_COUNT);
  assign stack_room   = free_count_q < CW'(ght_pkg::SLOT_COUNT);

  assign st_o.req_alloc      = (req_q.req_type == ght_pkg::REQ_ALLOC);
  assign st_o.stack_nonempty = (free_count_q != '0);
  assign st_o.out_valid      = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // request execution
  always_comb begin
    out_d        = '0;
    out_d.status = ght_pkg::ST_OK;
    free_count_d = free_count_q;
    high_water_d = high_water_q;
    gen_we       = 1'b0;
    rights_we    = 1'b0;
    err_we       = 1'b0;
    stack_we     = 1'b0;
    gen_wa       = req_idx;
    slot_wa      = req_idx;
    gen_wd       = gen_rd_q + GW'(1);
    err_wd       = ght_pkg::ST_OK;
    stack_wa     = free_count_q[IW-1:0];
    stack_wd     = req_idx;
    unique case (req_q.req_type)
      ght_pkg::REQ_ALLOC: begin
        if (free_count_q != '0) begin
          free_count_d         = fc_dec;
          slot_wa              = stack_rd_q;
          rights_we            = 1'b1;
          err_we               = 1'b1;
          out_d.out_index      = ght_pkg::OUT_INDEX_W'(stack_rd_q);
          out_d.out_generation = gen_rd_q;
        end else if (hw_avail) begin
          high_water_d         = high_water_q + CW'(1);
          slot_wa              = high_water_q[IW-1:0];
          gen_wa               = high_water_q[IW-1:0];
          gen_wd               = GW'(1);
          gen_we               = 1'b1;
          rights_we            = 1'b1;
          err_we               = 1'b1;
          out_d.out_index      = ght_pkg::OUT_INDEX_W'(high_water_q[IW-1:0]);
          out_d.out_generation = GW'(1);
        end else begin
          out_d.status = ght_pkg::ST_FULL;
        end
      end
      ght_pkg::REQ_RELEASE: begin
        if (!handle_ok) begin
          out_d.status = ght_pkg::ST_BAD_HANDLE;
        end else begin
          gen_we = 1'b1;
          if (stack_room) begin
            stack_we     = 1'b1;
            free_count_d = free_count_q + CW'(1);
          end
        end
      end
      ght_pkg::REQ_CHECK: begin
        if (!handle_ok) begin
          out_d.status = ght_pkg::ST_BAD_HANDLE;
        end else if ((rights_rd_q & req_q.access_mask) != req_q.access_mask) begin
          err_we       = 1'b1;
          err_wd       = ght_pkg::ST_PERM;
          out_d.status = ght_pkg::ST_PERM;
        end
      end
      ght_pkg::REQ_QUERY: begin
        if (!handle_ok) begin
          out_d.status = ght_pkg::ST_BAD_HANDLE;
        end else begin
          out_d.slot_error = err_rd_q;
        end
      end
      default: begin
        out_d.status = ght_pkg::ST_BAD_HANDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.exec) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // memories: one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && gen_we) gen_mem[gen_wa] <= gen_wd;
    if (cmd_i.rd_slot) gen_rd_q <= gen_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && rights_we) rights_mem[slot_wa] <= req_q.new_rights;
    if (cmd_i.rd_slot) rights_rd_q <= rights_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && err_we) err_mem[slot_wa] <= err_wd;
    if (cmd_i.rd_slot) err_rd_q <= err_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && stack_we) stack_mem[stack_wa] <= stack_wd;
    if (cmd_i.rd_stack) stack_rd_q <= stack_mem[fc_dec[IW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_data_i;
    if (cmd_i.exec) out_q <= out_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q <= '0;
      high_water_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.exec) begin
        free_count_q <= free_count_d;
        high_water_q <= high_water_d;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/generational_handle_table_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_table_unit
// slot table handing out index and generation handles, with rights checks
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               beat
//   in        sink       in_valid_i / in_stall_o  ght_pkg::in_item_t
//   out       source     out_valid_o / out_stall_i ght_pkg::out_item_t
//
// one request at a time: a read step, then an execute step, with a pop read
// step between them for an allocation that pops the free stack, as the slot
// memories are read through registers (the pop needs the stack read first,
// then the generation read at the popped slot); a new beat is taken in the
// execute cycle, so the result register and the next request overlap
// reset clears the free count, the high-water mark and the result valid;
// the slot memories need no clearing pass, entries are only used once written
// a stalled result holds the block in its execute step, no beat is lost
`timescale 1ns / 1ps
`default_nettype none

`include "generational_handle_table_unit_macros.svh"

module generational_handle_table_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ght_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ght_pkg::out_item_t     out_data_o
);

  // command and status between sequencer and datapath
  ght_pkg::ctrl_cmd_t  cmd;
  ght_pkg::dp_status_t st;

  // sequencer: capture, read, optional pop read, execute
  ght_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // memories, counters and result register
  ght_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // an accepted beat always spends its read cycle with the input stalled
  `GHT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // only a successful query shows a stored error
  `GHT_ASSERT_SAME(a_err_only_ok, out_valid_o && (out_data_o.slot_error != ght_pkg::ST_OK), out_data_o.status == ght_pkg::ST_OK)

  // a failed request carries no handle
  `GHT_ASSERT_SAME(a_fail_no_handle, out_valid_o && (out_data_o.status != ght_pkg::ST_OK), (out_data_o.out_index == '0) && (out_data_o.out_generation == '0))

  // the result is only written in the execute step, never over a waiting beat
  `GHT_ASSERT_SAME(a_no_overwrite, cmd.exec, !out_valid_o || !out_stall_i)

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the generational handle table unit
//
// a scoreboard class carries its own copy of the slot table (generations,
// rights, stored errors, free stack, high-water mark) and works out the
// result of every request beat the unit accepts; result beats are compared
// in order. stimulus is a short directed run, then random traffic built
// mostly from live handles, plus sequences that fill the table, overfill
// the free stack and drain it again. the sender idles in bursts, the
// receiver stalls on its own pattern and once holds off for a long stretch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ght_pkg::*;

  localparam longint TIMEOUT_NS   = 64'd10_000_000;
  localparam int     DRAIN_CYCLES = 20;
  localparam int     HOLD_CYCLES  = 300;              // long receiver hold-off

  // --------------------------------------------------------------------------
  // scoreboard: predicts each request's result and checks result beats
  // --------------------------------------------------------------------------
  class handle_table_scoreboard;
    logic [GEN_W-1:0]      slot_gen    [SLOT_COUNT];
    logic [RIGHTS_W-1:0]   slot_rights [SLOT_COUNT];
    logic [1:0]            slot_err    [SLOT_COUNT];
    logic [SLOT_IDX_W-1:0] free_slots  [SLOT_COUNT];
    int                    free_count;
    int                    high_water;
    out_item_t             expected_results[$];
    int                    mismatches;

    function new();
      free_count = 0;
      high_water = 0;
      mismatches = 0;
    endfunction

    // apply one accepted request to the table copy and queue its result
    function void note_request(in_item_t req);
      out_item_t             res;
      logic [SLOT_IDX_W-1:0] slot;
      bit                    live;
      res  = '0;
      slot = req.handle_index[SLOT_IDX_W-1:0];
      // an index past the high-water mark never reaches the generation compare
      live = (req.handle_index < 32'(high_water)) &&
             (slot_gen[slot] == req.handle_generation);
      if (req.req_type == REQ_ALLOC) begin
        if (free_count > 0) begin
          free_count--;
          slot = free_slots[free_count];
        end else if (high_water < SLOT_COUNT) begin
          slot = SLOT_IDX_W'(high_water);
          slot_gen[slot] = 32'd1;
          high_water++;
        end else begin
          res.status = ST_FULL;
        end
        if (res.status != ST_FULL) begin
          slot_err[slot]     = ST_OK;
          slot_rights[slot]  = req.new_rights;
          res.out_index      = slot;
          res.out_generation = slot_gen[slot];
        end
      end else if (!live) begin
        res.status = ST_BAD_HANDLE;
      end else if (req.req_type == REQ_RELEASE) begin
        slot_gen[slot] = slot_gen[slot] + 32'd1;
        // a full free stack still bumps the generation but drops the push
        if (free_count < SLOT_COUNT) begin
          free_slots[free_count] = slot;
          free_count++;
        end
      end else if (req.req_type == REQ_CHECK) begin
        if ((slot_rights[slot] & req.access_mask) != req.access_mask) begin
          slot_err[slot] = ST_PERM;
          res.status     = ST_PERM;
        end
      end else begin
        res.slot_error = slot_err[slot];
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat: status %0d index %0d gen %h err %0d",
                 $time, got.status, got.out_index, got.out_generation, got.slot_error);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: mismatch expected status %0d index %0d gen %h err %0d",
                   $time, want.status, want.out_index, want.out_generation,
                   want.slot_error);
          $display("%0t:          actual   status %0d index %0d gen %h err %0d",
                   $time, got.status, got.out_index, got.out_generation, got.slot_error);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and the unit
  // --------------------------------------------------------------------------
  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  handle_table_scoreboard table_sb = new();
  int beats_left_in_burst = 0;

  generational_handle_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // results are taken at the rising edge, stall was set up at the falling one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      table_sb.check_result(out_data_o);
    end
  end

  // --------------------------------------------------------------------------
  // request helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t make_request(logic [1:0] kind, logic [GEN_W-1:0] idx,
                                            logic [GEN_W-1:0] gen,
                                            logic [RIGHTS_W-1:0] mask,
                                            logic [RIGHTS_W-1:0] rights);
    in_item_t req;
    req.req_type          = kind;
    req.handle_index      = idx;
    req.handle_generation = gen;
    req.access_mask       = mask;
    req.new_rights        = rights;
    return req;
  endfunction

  // random rights field
  function automatic logic [RIGHTS_W-1:0] random_rights();
    return RIGHTS_W'($urandom_range(0, 7));
  endfunction

  // mostly live handles taken from the table copy; some stale generations,
  // some handles just past the high-water mark and some pure noise
  function automatic in_item_t random_request();
    int               pick;
    int               hw;
    logic [1:0]       kind;
    logic [GEN_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    hw   = table_sb.high_water;
    pick = $urandom_range(0, 99);
    if (pick < 25)      kind = REQ_ALLOC;
    else if (pick < 45) kind = REQ_RELEASE;
    else if (pick < 80) kind = REQ_CHECK;
    else                kind = REQ_QUERY;
    pick = $urandom_range(0, 9);
    if (hw > 0 && pick < 8) begin
      idx = $urandom_range(0, hw - 1);
      gen = table_sb.slot_gen[idx[SLOT_IDX_W-1:0]];
    end else if (hw > 0 && pick == 8) begin
      idx = $urandom_range(0, hw - 1);
      gen = table_sb.slot_gen[idx[SLOT_IDX_W-1:0]] ^ (32'd1 << $urandom_range(0, 31));
    end else if (pick == 9 && hw < SLOT_COUNT && $urandom_range(0, 1) == 1) begin
      idx = 32'(hw);
      gen = 32'd1;
    end else begin
      idx = $urandom;
      gen = $urandom;
    end
    return make_request(kind, idx, gen, random_rights(), random_rights());
  endfunction

  // entered and left at a falling edge; bursts of random length with gaps
  task automatic issue_request(in_item_t req);
    int gap;
    if (beats_left_in_burst == 0) begin
      beats_left_in_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    beats_left_in_burst--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    table_sb.note_request(req);
    @(negedge clk_i);
  endtask

  task automatic run_random(int count);
    repeat (count) issue_request(random_request());
  endtask

  task automatic alloc_until_full();
    while (table_sb.high_water < SLOT_COUNT || table_sb.free_count > 0) begin
      issue_request(make_request(REQ_ALLOC, $urandom, $urandom, random_rights(),
                                 random_rights()));
    end
    // table full, twice so that the unchanged state is seen again
    repeat (2) begin
      issue_request(make_request(REQ_ALLOC, $urandom, $urandom, random_rights(),
                                 random_rights()));
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver: stall pattern of its own, one long hold-off early in the run
  // --------------------------------------------------------------------------
  initial begin
    int seg_len;
    int mode;
    int seg_no;
    int phase;
    out_stall_i = 1'b0;
    seg_no      = 0;
    phase       = 0;
    @(posedge rst_ni);
    forever begin
      if (seg_no == 6) begin
        // sender keeps going, so the unit fills up and stalls its input
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        seg_len = $urandom_range(8, 60);
        mode    = $urandom_range(0, 3);
        repeat (seg_len) begin
          @(negedge clk_i);
          phase++;
          case (mode)
            0: begin
              out_stall_i <= 1'b0;
            end
            1: begin
              out_stall_i <= 1'($urandom_range(0, 1));
            end
            2: begin
              out_stall_i <= ($urandom_range(0, 4) != 0);
            end
            default: begin
              out_stall_i <= (phase % 3 == 0);
            end
          endcase
        end
      end
      seg_no++;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int target;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table: nothing is a valid handle yet
    issue_request(make_request(REQ_QUERY,   32'd0, 32'd0, 3'd0, 3'd0));
    issue_request(make_request(REQ_RELEASE, 32'd0, 32'd0, 3'd7, 3'd7));
    issue_request(make_request(REQ_CHECK,   32'd0, 32'd1, 3'd0, 3'd7));
    // first allocations come from the high-water mark with generation 1
    issue_request(make_request(REQ_ALLOC, 32'hffff_ffff, 32'hffff_ffff, 3'd7, 3'd7));
    issue_request(make_request(REQ_ALLOC, 32'd0, 32'd0, 3'd7, 3'd0));
    issue_request(make_request(REQ_CHECK, 32'd0, 32'd1, 3'd7, 3'd0));
    issue_request(make_request(REQ_CHECK, 32'd1, 32'd1, 3'd0, 3'd7));
    // rights failure is stored in the slot and seen by a query
    issue_request(make_request(REQ_CHECK, 32'd1, 32'd1, 3'd1, 3'd0));
    issue_request(make_request(REQ_QUERY, 32'd1, 32'd1, 3'd7, 3'd7));
    issue_request(make_request(REQ_QUERY, 32'd0, 32'd1, 3'd0, 3'd0));
    // bad handles: wrong generation, huge index, index at the high-water mark,
    // index that aliases slot 0 in its low bits
    issue_request(make_request(REQ_CHECK,   32'd0, 32'hffff_ffff, 3'd0, 3'd0));
    issue_request(make_request(REQ_CHECK,   32'hffff_ffff, 32'd1, 3'd0, 3'd0));
    issue_request(make_request(REQ_CHECK,   32'd2, 32'd1, 3'd0, 3'd0));
    issue_request(make_request(REQ_QUERY,   32'd64, 32'd1, 3'd0, 3'd0));
    issue_request(make_request(REQ_RELEASE, 32'h8000_0000, 32'h8000_0001, 3'd0, 3'd0));
    // release, then a free slot still answers to its current generation
    issue_request(make_request(REQ_RELEASE, 32'd1, 32'd1, 3'd0, 3'd0));
    issue_request(make_request(REQ_QUERY,   32'd1, 32'd2, 3'd0, 3'd0));
    issue_request(make_request(REQ_RELEASE, 32'd1, 32'd1, 3'd0, 3'd0));
    issue_request(make_request(REQ_RELEASE, 32'd1, 32'd2, 3'd0, 3'd0));
    // two pops of the same slot, then back to the high-water mark
    issue_request(make_request(REQ_ALLOC, 32'd0, 32'd0, 3'd0, 3'd5));
    issue_request(make_request(REQ_ALLOC, 32'd0, 32'd0, 3'd0, 3'd2));
    issue_request(make_request(REQ_ALLOC, 32'd0, 32'd0, 3'd0, 3'd4));
    issue_request(make_request(REQ_QUERY, 32'd1, 32'd3, 3'd0, 3'd0));
    issue_request(make_request(REQ_CHECK, 32'd1, 32'd3, 3'd2, 3'd0));
    issue_request(make_request(REQ_CHECK, 32'd0, 32'd1, 3'd4, 3'd0));

    run_random(220);
    alloc_until_full();
    run_random(130);

    // hammer one slot until the free stack holds every entry, then overflow it
    target = $urandom_range(0, SLOT_COUNT - 1);
    while (table_sb.free_count < SLOT_COUNT) begin
      issue_request(make_request(REQ_RELEASE, 32'(target),
                                 table_sb.slot_gen[target], random_rights(),
                                 random_rights()));
    end
    repeat (2) begin
      issue_request(make_request(REQ_RELEASE, 32'(target),
                                 table_sb.slot_gen[target], random_rights(),
                                 random_rights()));
    end
    alloc_until_full();
    run_random(100);

    in_valid_i <= 1'b0;
    while (table_sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (table_sb.mismatches == 0 && table_sb.expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hung handshake guard
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
